>>> rtl/lqr_pkg.sv
// Shared types, widths and helpers for the LQR wheel voltage controller.
// No dependencies; imported by every module of the block.
package lqr_pkg;

   // Fixed-point format of all payload words
   localparam int FRAC_BITS   = 10;
   localparam int WORD_W      = 16;
   localparam int STATE_SIZE  = 4;

   // Shared multiplier: 17x17 signed covers signed words and unsigned 15-bit settings
   localparam int MUL_W       = WORD_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = PROD_W + 3;

   // Job queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // Input item kinds
   localparam logic FUNC_WHEEL = 1'b0;
   localparam logic FUNC_PATH  = 1'b1;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [63:0] gain_left;
      logic [63:0] gain_right;
      logic [14:0] speed_base;
      logic [14:0] speed_term;
      logic [14:0] back_emf;
      logic [14:0] volt_limit;
      logic [7:0]  decimation;
   } cfg_type;

   // One control update handed from front to back
   typedef struct packed {
      logic signed [WORD_W-1:0] speed_left;
      logic signed [WORD_W-1:0] speed_right;
      logic signed [WORD_W-1:0] lateral;
      logic signed [WORD_W-1:0] heading;
      logic signed [WORD_W-1:0] curvature;
   } job_type;

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sd32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sd32768);

   // Saturate a wide signed value to the signed 16-bit range
   function automatic logic signed [WORD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > SAT_MAX) r = SAT_MAX;
      if (v < SAT_MIN) r = SAT_MIN;
      return r[WORD_W-1:0];
   endfunction

   // Gain element j of a packed row, element 0 in the low bits
   function automatic logic signed [WORD_W-1:0] gain_at(input logic [63:0] row,
                                                         input logic [1:0]  j);
      return row[WORD_W*j +: WORD_W];
   endfunction

endpackage

>>> rtl/lqr_front.sv
// Front end: accepts items, keeps the path error state and the decimation counter,
// and issues a job for every control update. Depends on lqr_pkg.
module lqr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_func,
   input  logic signed [15:0]         req_wheel_speed_left,
   input  logic signed [15:0]         req_wheel_speed_right,
   input  logic signed [15:0]         req_lateral_error_in,
   input  logic signed [15:0]         req_heading_error_in,
   input  logic signed [15:0]         req_curvature_in,
   input  logic [7:0]                 decimation,
   input  logic                       queue_full,
   output logic                       job_push,
   output lqr_pkg::job_type           job
);
   import lqr_pkg::*;

   logic signed [WORD_W-1:0] lateral_ff,   lateral_in;
   logic signed [WORD_W-1:0] heading_ff,   heading_in;
   logic signed [WORD_W-1:0] curvature_ff, curvature_in;
   logic [7:0]               count_ff,     count_in;
   logic                     path_seen_ff, path_seen_in;
   logic                     accept;
   logic [7:0]               count_next;
   logic                     tick;

   // Classify the accepted item
   assign accept     = req_push && !queue_full;
   assign count_next = count_ff + 8'd1;
   assign tick       = (count_next >= decimation);

   always_comb begin
      lateral_in   = lateral_ff;
      heading_in   = heading_ff;
      curvature_in = curvature_ff;
      path_seen_in = path_seen_ff;
      count_in     = count_ff;
      job_push     = 1'b0;
      if (accept) begin
         if (req_func == FUNC_PATH) begin
            lateral_in   = req_lateral_error_in;
            heading_in   = req_heading_error_in;
            curvature_in = req_curvature_in;
            path_seen_in = 1'b1;
         end else begin
            count_in = tick ? 8'd0 : count_next;
            job_push = tick && path_seen_ff;
         end
      end
   end

   // Snapshot of the path state travels with the job
   assign job.speed_left  = req_wheel_speed_left;
   assign job.speed_right = req_wheel_speed_right;
   assign job.lateral     = lateral_ff;
   assign job.heading     = heading_ff;
   assign job.curvature   = curvature_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lateral_ff   <= '0;
         heading_ff   <= '0;
         curvature_ff <= '0;
         count_ff     <= '0;
         path_seen_ff <= 1'b0;
      end else begin
         lateral_ff   <= lateral_in;
         heading_ff   <= heading_in;
         curvature_ff <= curvature_in;
         count_ff     <= count_in;
         path_seen_ff <= path_seen_in;
      end
   end

endmodule

>>> rtl/lqr_queue.sv
// Short job queue that decouples the front end from the back end.
// Depends on lqr_pkg (job_type).
module lqr_queue #(
   parameter int DEPTH = lqr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lqr_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             valid,
   output lqr_pkg::job_type head_job
);
   import lqr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign head_job = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_job;
   end

endmodule

>>> rtl/lqr_back.sv
// Back end: works one job through a shared 17x17 multiplier, one product per
// cycle, then clamps and holds the result until popped. Depends on lqr_pkg.
module lqr_back (
   input  logic                clock,
   input  logic                reset,
   input  lqr_pkg::cfg_type    cfg,
   input  logic                job_valid,
   input  lqr_pkg::job_type    job,
   output logic                job_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic signed [15:0]  rsp_voltage_left,
   output logic signed [15:0]  rsp_voltage_right
);
   import lqr_pkg::*;

   // Step codes: TURN to R3 each issue one product, and L0 to LAST each consume the previous one
   localparam logic [3:0] STEP_TURN  = 4'd0;   // curvature * term
   localparam logic [3:0] STEP_L0    = 4'd1;   // take turn; gain L0 * lateral
   localparam logic [3:0] STEP_VL    = 4'd2;   // acc L; emf * wl
   localparam logic [3:0] STEP_VR    = 4'd3;   // take vl_nom; emf * wr
   localparam logic [3:0] STEP_R0    = 4'd4;   // take vr_nom; gain R0 * lateral
   localparam logic [3:0] STEP_L1    = 4'd5;
   localparam logic [3:0] STEP_R1    = 4'd6;
   localparam logic [3:0] STEP_L2    = 4'd7;
   localparam logic [3:0] STEP_R2    = 4'd8;
   localparam logic [3:0] STEP_L3    = 4'd9;
   localparam logic [3:0] STEP_R3    = 4'd10;
   localparam logic [3:0] STEP_LAST  = 4'd11;  // acc R only
   localparam logic [3:0] STEP_DONE  = 4'd12;  // clamp and write result

   logic                     busy_ff, busy_in;
   logic [3:0]               step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] shifted;
   logic signed [ACC_W-1:0]  term_ext;
   logic signed [WORD_W-1:0] wl_ff, wr_ff, vl_nom_ff, vr_nom_ff, x2_ff, x3_ff;
   logic signed [ACC_W-1:0]  ul_ff, ur_ff;
   logic                     out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] vout_l_ff, vout_r_ff;
   logic signed [ACC_W-1:0]  lim_pos, lim_neg, sum_l, sum_r, clamp_l, clamp_r;
   logic                     finish;

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         STEP_TURN: begin
            mul_a = MUL_W'(job.curvature);
            mul_b = signed'(MUL_W'(cfg.speed_term));
         end
         STEP_L0: begin
            mul_a = MUL_W'(gain_at(cfg.gain_left, 2'd0));
            mul_b = MUL_W'(job.lateral);
         end
         STEP_VL: begin
            mul_a = signed'(MUL_W'(cfg.back_emf));
            mul_b = MUL_W'(wl_ff);
         end
         STEP_VR: begin
            mul_a = signed'(MUL_W'(cfg.back_emf));
            mul_b = MUL_W'(wr_ff);
         end
         STEP_R0: begin
            mul_a = MUL_W'(gain_at(cfg.gain_right, 2'd0));
            mul_b = MUL_W'(job.lateral);
         end
         STEP_L1: begin
            mul_a = MUL_W'(gain_at(cfg.gain_left, 2'd1));
            mul_b = MUL_W'(job.heading);
         end
         STEP_R1: begin
            mul_a = MUL_W'(gain_at(cfg.gain_right, 2'd1));
            mul_b = MUL_W'(job.heading);
         end
         STEP_L2: begin
            mul_a = MUL_W'(gain_at(cfg.gain_left, 2'd2));
            mul_b = MUL_W'(x2_ff);
         end
         STEP_R2: begin
            mul_a = MUL_W'(gain_at(cfg.gain_right, 2'd2));
            mul_b = MUL_W'(x2_ff);
         end
         STEP_L3: begin
            mul_a = MUL_W'(gain_at(cfg.gain_left, 2'd3));
            mul_b = MUL_W'(x3_ff);
         end
         STEP_R3: begin
            mul_a = MUL_W'(gain_at(cfg.gain_right, 2'd3));
            mul_b = MUL_W'(x3_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Product truncated toward minus infinity
   assign shifted  = prod_ff >>> FRAC_BITS;
   assign term_ext = ACC_W'(shifted);

   // Final sums and clamp
   assign lim_pos = signed'(ACC_W'(cfg.volt_limit));
   assign lim_neg = -lim_pos;
   assign sum_l   = ACC_W'(vl_nom_ff) + ul_ff;
   assign sum_r   = ACC_W'(vr_nom_ff) + ur_ff;

   always_comb begin
      clamp_l = sum_l;
      if (sum_l > lim_pos) clamp_l = lim_pos;
      if (sum_l < lim_neg) clamp_l = lim_neg;
      clamp_r = sum_r;
      if (sum_r > lim_pos) clamp_r = lim_pos;
      if (sum_r < lim_neg) clamp_r = lim_neg;
   end

   // Sequencer control
   assign finish  = busy_ff && (step_ff == STEP_DONE) && (!out_valid_ff || rsp_pop);
   assign job_pop = finish;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;
      if (!busy_ff) begin
         if (job_valid) begin
            busy_in = 1'b1;
            step_in = STEP_TURN;
         end
      end else if (step_ff == STEP_DONE) begin
         if (finish) begin
            busy_in      = 1'b0;
            out_valid_in = 1'b1;
         end
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_TURN;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (busy_ff) begin
         case (step_ff)
            STEP_TURN: begin
               ul_ff <= '0;
               ur_ff <= '0;
            end
            STEP_L0: begin
               wl_ff <= sat16(signed'(ACC_W'(cfg.speed_base)) - term_ext);
               wr_ff <= sat16(signed'(ACC_W'(cfg.speed_base)) + term_ext);
            end
            STEP_VL: begin
               ul_ff <= ul_ff - term_ext;
               x2_ff <= sat16(ACC_W'(job.speed_left) - ACC_W'(wl_ff));
               x3_ff <= sat16(ACC_W'(job.speed_right) - ACC_W'(wr_ff));
            end
            STEP_VR:   vl_nom_ff <= sat16(term_ext);
            STEP_R0:   vr_nom_ff <= sat16(term_ext);
            STEP_L1, STEP_L2, STEP_L3, STEP_LAST: ur_ff <= ur_ff - term_ext;
            STEP_R1, STEP_R2, STEP_R3:            ul_ff <= ul_ff - term_ext;
            default: ;
         endcase
      end
      if (finish) begin
         vout_l_ff <= clamp_l[WORD_W-1:0];
         vout_r_ff <= clamp_r[WORD_W-1:0];
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_voltage_left  = vout_l_ff;
   assign rsp_voltage_right = vout_r_ff;

endmodule

>>> rtl/lqr_wheel_voltage_controller_top.sv
// LQR wheel voltage controller, one item is path error data or a wheel
// speed sample; every decimation-th wheel sample, once path data has been
// seen, yields one pair of clamped motor voltages. Any item is accepted
// while the job queue has room. A triggering sample is queued (two-entry
// job queue); the back end picks the job up from the queue once it is idle
// and works it through eleven products on one shared 17x17 multiplier, one
// per cycle, then the last accumulate and the sum and clamp. The back end
// takes a new job only after the last one is finished and its result has
// gone into the output register. The result is held in an output register
// until popped; meanwhile new items keep being accepted until the job
// queue fills.
// Registers sit on an APB port at 8-byte spacing and should be written only
// while the block is idle. Depends on lqr_pkg, lqr_front, lqr_queue, lqr_back.
module lqr_wheel_voltage_controller_top #(
   parameter int QUEUE_DEPTH = lqr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               push,
   output logic               full,
   input  logic               req_func,
   input  logic signed [15:0] req_wheel_speed_left,
   input  logic signed [15:0] req_wheel_speed_right,
   input  logic signed [15:0] req_lateral_error_in,
   input  logic signed [15:0] req_heading_error_in,
   input  logic signed [15:0] req_curvature_in,
   // result channel
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_voltage_left,
   output logic signed [15:0] rsp_voltage_right,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);
   import lqr_pkg::*;

   // Register indexes
   localparam logic [2:0] REG_GAIN_LEFT  = 3'd0;
   localparam logic [2:0] REG_GAIN_RIGHT = 3'd1;
   localparam logic [2:0] REG_BASE       = 3'd2;
   localparam logic [2:0] REG_TERM       = 3'd3;
   localparam logic [2:0] REG_EMF        = 3'd4;
   localparam logic [2:0] REG_LIMIT      = 3'd5;
   localparam logic [2:0] REG_DECIM      = 3'd6;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_index;
   logic       queue_full, queue_valid, job_push, job_pop;
   job_type    push_job, head_job;

   // Configuration registers
   assign pready    = 1'b1;
   assign reg_index = paddr[5:3];
   assign wr_en     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_left  <= '0;
         cfg_ff.gain_right <= '0;
         cfg_ff.speed_base <= 15'd6206;
         cfg_ff.speed_term <= 15'd317;
         cfg_ff.back_emf   <= 15'd489;
         cfg_ff.volt_limit <= 15'd5120;
         cfg_ff.decimation <= 8'd5;
      end else if (wr_en) begin
         case (reg_index)
            REG_GAIN_LEFT:  cfg_ff.gain_left  <= pwdata;
            REG_GAIN_RIGHT: cfg_ff.gain_right <= pwdata;
            REG_BASE:       cfg_ff.speed_base <= pwdata[14:0];
            REG_TERM:       cfg_ff.speed_term <= pwdata[14:0];
            REG_EMF:        cfg_ff.back_emf   <= pwdata[14:0];
            REG_LIMIT:      cfg_ff.volt_limit <= pwdata[14:0];
            REG_DECIM:      cfg_ff.decimation <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read-back
   always_comb begin
      case (reg_index)
         REG_GAIN_LEFT:  prdata = cfg_ff.gain_left;
         REG_GAIN_RIGHT: prdata = cfg_ff.gain_right;
         REG_BASE:       prdata = 64'(cfg_ff.speed_base);
         REG_TERM:       prdata = 64'(cfg_ff.speed_term);
         REG_EMF:        prdata = 64'(cfg_ff.back_emf);
         REG_LIMIT:      prdata = 64'(cfg_ff.volt_limit);
         REG_DECIM:      prdata = 64'(cfg_ff.decimation);
         default:        prdata = '0;
      endcase
   end

   assign full = queue_full;

   lqr_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (push),
      .req_func              (req_func),
      .req_wheel_speed_left  (req_wheel_speed_left),
      .req_wheel_speed_right (req_wheel_speed_right),
      .req_lateral_error_in  (req_lateral_error_in),
      .req_heading_error_in  (req_heading_error_in),
      .req_curvature_in      (req_curvature_in),
      .decimation            (cfg_ff.decimation),
      .queue_full            (queue_full),
      .job_push              (job_push),
      .job                   (push_job)
   );

   lqr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .full     (queue_full),
      .valid    (queue_valid),
      .head_job (head_job)
   );

   lqr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .job_valid         (queue_valid),
      .job               (head_job),
      .job_pop           (job_pop),
      .rsp_pop           (pop),
      .rsp_empty         (empty),
      .rsp_voltage_left  (rsp_voltage_left),
      .rsp_voltage_right (rsp_voltage_right)
   );

endmodule

>>> dv/tb.sv
// Self-checking testbench for lqr_wheel_voltage_controller_top: directed table, then random beats.
// Voltages are predicted in-bench and checked beat by beat; depends on lqr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
   import lqr_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES       = 9;
   localparam int PHASE_BEATS  = 211;

   typedef enum int {
      REG_GAIN_LEFT, REG_GAIN_RIGHT, REG_SPEED_BASE, REG_SPEED_TERM,
      REG_BACK_EMF, REG_VOLT_LIMIT, REG_DECIMATION
   } reg_index_type;

   typedef enum int { ROW_ITEM, ROW_WRITE } row_kind_type;

   typedef struct {
      logic               func;
      logic signed [15:0] speed_l;
      logic signed [15:0] speed_r;
      logic signed [15:0] lat;
      logic signed [15:0] head;
      logic signed [15:0] curv;
      bit                 typed;     // expected voltages given in the table
      logic signed [15:0] exp_left;
      logic signed [15:0] exp_right;
   } item_type;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } volts_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type index;
      logic [63:0]   value;
      item_type      it;
   } plan_row_type;

   // DUT interface
   logic               clock, reset;
   logic               push, full, empty, pop;
   logic               req_func;
   logic signed [15:0] req_wheel_speed_left, req_wheel_speed_right;
   logic signed [15:0] req_lateral_error_in, req_heading_error_in, req_curvature_in;
   logic signed [15:0] rsp_voltage_left, rsp_voltage_right;
   logic               psel, penable, pwrite, pready;
   logic [5:0]         paddr;
   logic [63:0]        pwdata, prdata;

   lqr_wheel_voltage_controller_top dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_func(req_func),
      .req_wheel_speed_left(req_wheel_speed_left),
      .req_wheel_speed_right(req_wheel_speed_right),
      .req_lateral_error_in(req_lateral_error_in),
      .req_heading_error_in(req_heading_error_in),
      .req_curvature_in(req_curvature_in),
      .empty(empty), .pop(pop),
      .rsp_voltage_left(rsp_voltage_left), .rsp_voltage_right(rsp_voltage_right),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Controller shadow: settings and error state
   logic [63:0] cfg_gain_l, cfg_gain_r;
   logic [14:0] cfg_base, cfg_term, cfg_emf, cfg_limit;
   logic [7:0]  cfg_decimation;
   longint      path_lat, path_head, path_curv;
   logic [7:0]  tick_count;
   bit          have_path;

   volts_type    volts_due[$];
   plan_row_type plan[$];
   int           send_idle, recv_idle;
   int           errors;
   int           cycle_count;

   // Q5.10 product, low bits dropped (floor)
   function automatic longint qmul(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint gain_word(input logic [63:0] row, input int j);
      return longint'($signed(row[16*j +: 16]));
   endfunction

   // Advance the shadow state by one beat; returns 1 when a voltage pair is due
   function automatic bit predict_voltages(input item_type it, output volts_type v);
      longint turn, wl_nom, wr_nom, vl_nom, vr_nom, ul, ur, vl, vr, lim;
      longint xs [4];
      v.left  = '0;
      v.right = '0;
      if (it.func == FUNC_PATH) begin
         path_lat  = longint'(it.lat);
         path_head = longint'(it.head);
         path_curv = longint'(it.curv);
         have_path = 1'b1;
         return 1'b0;
      end
      tick_count = tick_count + 8'd1;
      if (tick_count < cfg_decimation) return 1'b0;
      tick_count = '0;
      if (!have_path) return 1'b0;

      // nominal wheel speeds and voltages from curvature
      turn   = qmul(path_curv, longint'(cfg_term));
      wl_nom = clip16(longint'(cfg_base) - turn);
      wr_nom = clip16(longint'(cfg_base) + turn);
      vl_nom = clip16(qmul(longint'(cfg_emf), wl_nom));
      vr_nom = clip16(qmul(longint'(cfg_emf), wr_nom));

      xs[0] = path_lat;
      xs[1] = path_head;
      xs[2] = clip16(longint'(it.speed_l) - wl_nom);
      xs[3] = clip16(longint'(it.speed_r) - wr_nom);

      // u = -K*x, kept exact
      ul = 0;
      ur = 0;
      for (int j = 0; j < 4; j++) begin
         ul -= qmul(gain_word(cfg_gain_l, j), xs[j]);
         ur -= qmul(gain_word(cfg_gain_r, j), xs[j]);
      end

      lim = longint'(cfg_limit);
      vl  = vl_nom + ul;
      vr  = vr_nom + ur;
      if (vl > lim) vl = lim;
      if (vl < -lim) vl = -lim;
      if (vr > lim) vr = lim;
      if (vr < -lim) vr = -lim;
      v.left  = 16'(vl);
      v.right = 16'(vr);
      return 1'b1;
   endfunction

   // Random word: extremes, small values near zero, or anything
   function automatic logic signed [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'(int'($urandom_range(4095)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_gains();
      logic [63:0] row;
      for (int j = 0; j < 4; j++)
         row[16*j +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'(int'($urandom_range(4095)) - 2048);
      return row;
   endfunction

   function automatic item_type random_item();
      item_type it;
      it.func      = ($urandom_range(99) < 20) ? FUNC_PATH : FUNC_WHEEL;
      it.speed_l   = pick_word();
      it.speed_r   = pick_word();
      it.lat       = pick_word();
      it.head      = pick_word();
      it.curv      = pick_word();
      it.typed     = 1'b0;
      it.exp_left  = '0;
      it.exp_right = '0;
      return it;
   endfunction

   // Directed table rows
   function automatic plan_row_type wheel_row(input logic signed [15:0] l,
                                              input logic signed [15:0] r,
                                              input bit typed = 1'b0,
                                              input logic signed [15:0] el = '0,
                                              input logic signed [15:0] er = '0);
      plan_row_type row;
      row.kind         = ROW_ITEM;
      row.index        = REG_GAIN_LEFT;
      row.value        = '0;
      row.it           = random_item();
      row.it.func      = FUNC_WHEEL;
      row.it.speed_l   = l;
      row.it.speed_r   = r;
      row.it.typed     = typed;
      row.it.exp_left  = el;
      row.it.exp_right = er;
      return row;
   endfunction

   function automatic plan_row_type path_row(input logic signed [15:0] lat,
                                             input logic signed [15:0] head,
                                             input logic signed [15:0] curv);
      plan_row_type row;
      row.kind    = ROW_ITEM;
      row.index   = REG_GAIN_LEFT;
      row.value   = '0;
      row.it      = random_item();
      row.it.func = FUNC_PATH;
      row.it.lat  = lat;
      row.it.head = head;
      row.it.curv = curv;
      return row;
   endfunction

   function automatic plan_row_type write_row(input reg_index_type idx,
                                              input logic [63:0] value);
      plan_row_type row;
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.value = value;
      row.it    = random_item();
      return row;
   endfunction

   // Input beat: random gap, then hold until accepted
   task automatic send_item(input item_type it);
      volts_type v;
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push                  <= 1'b1;
      req_func              <= it.func;
      req_wheel_speed_left  <= it.speed_l;
      req_wheel_speed_right <= it.speed_r;
      req_lateral_error_in  <= it.lat;
      req_heading_error_in  <= it.head;
      req_curvature_in      <= it.curv;
      @(posedge clock);
      while (full) @(posedge clock);
      if (predict_voltages(it, v)) begin
         if (it.typed) begin
            v.left  = it.exp_left;
            v.right = it.exp_right;
         end
         volts_due.push_back(v);
      end
      @(negedge clock);
   endtask

   // Stop pushing, wait for every voltage pair and for the back end to settle
   task automatic wait_idle();
      push <= 1'b0;
      while (volts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write: setup phase, access phase, then the bus goes quiet with psel low
   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 6'(int'(idx) * 8);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_GAIN_LEFT:  cfg_gain_l     = value;
         REG_GAIN_RIGHT: cfg_gain_r     = value;
         REG_SPEED_BASE: cfg_base       = value[14:0];
         REG_SPEED_TERM: cfg_term       = value[14:0];
         REG_BACK_EMF:   cfg_emf        = value[14:0];
         REG_VOLT_LIMIT: cfg_limit      = value[14:0];
         REG_DECIMATION: cfg_decimation = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls
   always @(negedge clock)
      pop <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle);

   // Result check against the oldest expected pair
   always @(posedge clock) begin : check_beat
      volts_type want;
      if (!reset && pop && !empty) begin
         if (volts_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected voltage beat: L=%0d R=%0d",
                        rsp_voltage_left, rsp_voltage_right);
         end else begin
            want = volts_due.pop_front();
            if (rsp_voltage_left !== want.left || rsp_voltage_right !== want.right) begin
               errors++;
               if (errors <= 10)
                  $display("voltage mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                           want.left, want.right, rsp_voltage_left, rsp_voltage_right);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** lqr_wheel_voltage_controller_top: FAILED **");
         $finish;
      end
   end

   initial begin : main
      logic [63:0] vals [7];
      reset                 = 1'b1;
      push                  = 1'b0;
      req_func              = FUNC_WHEEL;
      req_wheel_speed_left  = '0;
      req_wheel_speed_right = '0;
      req_lateral_error_in  = '0;
      req_heading_error_in  = '0;
      req_curvature_in      = '0;
      pop                   = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      errors                = 0;
      cycle_count           = 0;
      send_idle             = 6;
      recv_idle             = 81;

      // reset values of the shadow
      cfg_gain_l     = '0;
      cfg_gain_r     = '0;
      cfg_base       = 15'd6206;
      cfg_term       = 15'd317;
      cfg_emf        = 15'd489;
      cfg_limit      = 15'd5120;
      cfg_decimation = 8'd5;
      path_lat       = 0;
      path_head      = 0;
      path_curv      = 0;
      tick_count     = '0;
      have_path      = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // decimation tick before any path data: counter wraps, nothing out
      plan.push_back(wheel_row(16'sh7FFF, 16'sh8000));
      plan.push_back(wheel_row(16'sh8000, 16'sh7FFF));
      plan.push_back(wheel_row(16'sh0000, 16'shFFFF));
      plan.push_back(wheel_row(16'sh7FFF, 16'sh7FFF));
      plan.push_back(wheel_row(16'sh8000, 16'sh8000));
      // reset settings, zero gains, straight path: nominal voltage only
      plan.push_back(path_row(16'sh0000, 16'sh0000, 16'sh0000));
      plan.push_back(wheel_row(16'sh0100, 16'sh0100));
      plan.push_back(wheel_row(16'shFF00, 16'sh0100));
      plan.push_back(wheel_row(16'sh7FFF, 16'sh8000));
      plan.push_back(wheel_row(16'sh1000, 16'sh1000));
      plan.push_back(wheel_row(16'sh1111, 16'sh2222, 1'b1, 16'sd2963, 16'sd2963));
      // every wheel beat fires; curvature extremes saturate one side
      plan.push_back(write_row(REG_DECIMATION, 64'd1));
      plan.push_back(path_row(16'sh7FFF, 16'sh8000, 16'sh7FFF));
      plan.push_back(wheel_row(16'sh7FFF, 16'sh8000, 1'b1, -16'sd1881, 16'sd5120));
      plan.push_back(path_row(16'sh8000, 16'sh7FFF, 16'sh8000));
      plan.push_back(wheel_row(16'sh8000, 16'sh7FFF, 1'b1, 16'sd5120, -16'sd1881));
      // unit gains, zero limit clamps everything to zero, then a wide limit with a new path
      plan.push_back(write_row(REG_GAIN_LEFT, 64'h0400_0400_0400_0400));
      plan.push_back(write_row(REG_GAIN_RIGHT, 64'hFC00_FC00_FC00_FC00));
      plan.push_back(write_row(REG_VOLT_LIMIT, 64'd0));
      plan.push_back(wheel_row(16'sh7FFF, 16'sh8000, 1'b1, 16'sd0, 16'sd0));
      plan.push_back(write_row(REG_VOLT_LIMIT, 64'd32767));
      plan.push_back(path_row(16'sh7FFF, 16'sh7FFF, 16'sh0000));
      plan.push_back(wheel_row(16'sh8000, 16'sh8000));
      plan.push_back(wheel_row(16'sh7FFF, 16'sh7FFF));
      // decimation zero: every wheel beat is an update
      plan.push_back(write_row(REG_DECIMATION, 64'd0));
      plan.push_back(wheel_row(16'sh0400, 16'shFC00));
      plan.push_back(wheel_row(16'sh0000, 16'sh0000));
      // decimation lowered below the running count fires on the next beat
      plan.push_back(write_row(REG_DECIMATION, 64'd8));
      plan.push_back(wheel_row(16'sh0001, 16'sh0002));
      plan.push_back(wheel_row(16'sh0003, 16'sh0004));
      plan.push_back(wheel_row(16'sh0005, 16'sh0006));
      plan.push_back(write_row(REG_DECIMATION, 64'd2));
      plan.push_back(wheel_row(16'sh0007, 16'sh0008));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            send_item(plan[i].it);
         end
      end

      // random phases: idling pattern changes every third phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 3)
            0: begin send_idle = 6;  recv_idle = 81; end
            1: begin send_idle = 81; recv_idle = 6;  end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         vals[REG_GAIN_LEFT]  = pick_gains();
         vals[REG_GAIN_RIGHT] = pick_gains();
         vals[REG_SPEED_BASE] = 64'($urandom_range(32767));
         vals[REG_SPEED_TERM] = 64'($urandom_range(4095));
         vals[REG_BACK_EMF]   = 64'($urandom_range(2047));
         vals[REG_VOLT_LIMIT] = 64'($urandom_range(32767));
         vals[REG_DECIMATION] = 64'($urandom_range(4, 1));
         case (phase)
            1: begin
               vals[REG_GAIN_LEFT]  = 64'h8000_7FFF_8000_7FFF;
               vals[REG_GAIN_RIGHT] = 64'h7FFF_8000_7FFF_8000;
               vals[REG_SPEED_BASE] = 64'd32767;
               vals[REG_SPEED_TERM] = 64'd32767;
               vals[REG_BACK_EMF]   = 64'd32767;
               vals[REG_VOLT_LIMIT] = 64'd32767;
               vals[REG_DECIMATION] = 64'd1;
            end
            4: begin
               vals[REG_SPEED_BASE] = 64'd0;
               vals[REG_SPEED_TERM] = 64'd0;
               vals[REG_BACK_EMF]   = 64'd0;
               vals[REG_DECIMATION] = 64'd2;
            end
            7: vals[REG_DECIMATION] = 64'd255;
            default: ;
         endcase
         wait_idle();
         for (int r = 0; r < 7; r++)
            write_reg(reg_index_type'(r), vals[r]);
         repeat (PHASE_BEATS) send_item(random_item());
      end

      wait_idle();
      if (errors == 0 && volts_due.size() == 0)
         $display("** lqr_wheel_voltage_controller_top: PASSED **");
      else
         $display("** lqr_wheel_voltage_controller_top: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
rtl/lqr_pkg.sv
rtl/lqr_front.sv
rtl/lqr_queue.sv
rtl/lqr_back.sv
rtl/lqr_wheel_voltage_controller_top.sv
dv/tb.sv
